// File: hdl/chenc_pkg.sv
// ----------------------------------------------------------------------------
// chenc_pkg
// shared constants, request codes and job type for the canonical huffman
// encoder
// ----------------------------------------------------------------------------
`default_nettype none

package chenc_pkg;

    localparam int MAX_CODE_LEN = 16;
    localparam int ALPHABET     = 256;

    localparam int REQ_W  = 3;
    localparam int LEN_W  = 5;
    localparam int CNT_W  = 9;
    localparam int BYTE_W = 8;

    localparam int SYM_W  = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int LIDX_W = $clog2(MAX_CODE_LEN + 1);
    localparam int SUM_W  = ((MAX_CODE_LEN > CNT_W) ? MAX_CODE_LEN : CNT_W) + 1;
    localparam int SH_W   = MAX_CODE_LEN + BYTE_W;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam logic [REQ_W-1:0] REQ_SET_COUNT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_FINALIZE  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_ASSIGN    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_ENCODE    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_FLUSH     = 3'd4;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [0:0] REG_LONGEST = 1'b0;

    typedef struct packed {
        logic                    is_flush;
        logic [LEN_W-1:0]        len;
        logic [MAX_CODE_LEN-1:0] code;
    } t_job;

    typedef struct packed {
        logic empty;
        logic almost_full;
        logic full;
    } t_qstat;

endpackage

`default_nettype wire

// File: hdl/chenc_front.sv
// ----------------------------------------------------------------------------
// chenc_front
// accepts request beats, keeps the code tables and turns encode and flush
// beats into jobs for the bit packer
// ----------------------------------------------------------------------------
`default_nettype none

module chenc_front (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic [chenc_pkg::REQ_W-1:0]        i_req_type,
    input  wire logic [chenc_pkg::LEN_W-1:0]        i_code_length,
    input  wire logic [chenc_pkg::CNT_W-1:0]        i_symbol_count,
    input  wire logic [chenc_pkg::BYTE_W-1:0]       i_byte_value,
    input  wire logic [chenc_pkg::LEN_W-1:0]        i_longest,
    input  wire chenc_pkg::t_qstat                  i_qstat,
    output logic                                    o_push,
    output chenc_pkg::t_job                         o_job,
    output logic                                    o_fin_busy
);

    localparam int MAXL = chenc_pkg::MAX_CODE_LEN;
    localparam int CW   = chenc_pkg::MAX_CODE_LEN;
    localparam int LW   = chenc_pkg::LEN_W;
    localparam int IW   = chenc_pkg::LIDX_W;
    localparam int NW   = chenc_pkg::CNT_W;
    localparam int SW   = chenc_pkg::SUM_W;
    localparam int YW   = chenc_pkg::SYM_W;
    localparam logic [LW-1:0] MAXL_L = LW'(MAXL);

    logic [NW-1:0] r_cnt   [0:MAXL];
    logic [CW-1:0] r_first [0:MAXL];
    logic [NW-1:0] r_off   [0:MAXL];

    logic [LW+CW-1:0] r_mem [0:chenc_pkg::ALPHABET-1];
    logic             r_cvalid [0:chenc_pkg::ALPHABET-1];

    logic            r_fin_busy;
    logic [IW-1:0]   r_fin_idx;
    logic            r_s1_valid;
    logic [chenc_pkg::REQ_W-1:0] r_s1_req;
    logic [LW+CW-1:0] r_rd_word;
    logic            r_rd_vld;

    logic            accept;
    logic            len_ok;
    logic            sym_ok;
    logic [IW-1:0]   lidx;
    logic [YW-1:0]   sidx;
    logic            asg_ok;
    logic [CW-1:0]   asg_code;
    logic [LW-1:0]   top;
    logic [IW-1:0]   fin_up;
    logic [SW-1:0]   fin_sum;

    assign o_stall    = r_fin_busy || i_qstat.almost_full;
    assign o_fin_busy = r_fin_busy;
    assign accept     = i_valid && !o_stall;

    assign len_ok = (i_code_length != '0) && (i_code_length <= MAXL_L);
    assign sym_ok = {1'b0, i_byte_value} < 9'(chenc_pkg::ALPHABET);
    assign lidx   = i_code_length[IW-1:0];
    assign sidx   = i_byte_value[YW-1:0];

    assign asg_ok   = len_ok && sym_ok && (r_off[lidx] < r_cnt[lidx]);
    assign asg_code = CW'(SW'(r_first[lidx]) + SW'(r_off[lidx]));

    always_comb begin
        if (i_longest == '0) begin
            top = LW'(1);
        end else if (i_longest > MAXL_L) begin
            top = MAXL_L;
        end else begin
            top = i_longest;
        end
    end

    assign fin_up  = IW'(r_fin_idx + 1'b1);
    assign fin_sum = SW'(r_first[fin_up]) + SW'(r_cnt[fin_up]);

    // length tables and finalize walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= MAXL; i++) begin
                r_cnt[i]   <= '0;
                r_first[i] <= '0;
                r_off[i]   <= '0;
            end
            r_fin_busy <= 1'b0;
            r_fin_idx  <= '0;
        end else if (r_fin_busy) begin
            r_first[r_fin_idx] <= CW'(fin_sum >> 1);
            r_fin_idx          <= IW'(r_fin_idx - 1'b1);
            if (r_fin_idx == IW'(1)) begin
                r_fin_busy <= 1'b0;
            end
        end else if (accept) begin
            unique case (i_req_type)
                chenc_pkg::REQ_SET_COUNT: begin
                    if (len_ok) begin
                        r_cnt[lidx] <= i_symbol_count;
                    end
                end
                chenc_pkg::REQ_FINALIZE: begin
                    for (int i = 0; i <= MAXL; i++) begin
                        r_first[i] <= '0;
                        r_off[i]   <= '0;
                    end
                    r_fin_idx  <= IW'(top - 1'b1);
                    r_fin_busy <= (top > LW'(1));
                end
                chenc_pkg::REQ_ASSIGN: begin
                    if (asg_ok) begin
                        r_off[lidx] <= NW'(r_off[lidx] + 1'b1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // code memory, registered read
    always_ff @(posedge i_clk) begin
        if (accept && i_req_type == chenc_pkg::REQ_ASSIGN && asg_ok) begin
            r_mem[sidx] <= {i_code_length, asg_code};
        end
        if (accept) begin
            r_rd_word <= r_mem[sidx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < chenc_pkg::ALPHABET; i++) begin
                r_cvalid[i] <= 1'b0;
            end
            r_rd_vld   <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s1_req   <= chenc_pkg::REQ_SET_COUNT;
        end else begin
            if (accept && i_req_type == chenc_pkg::REQ_ASSIGN && asg_ok) begin
                r_cvalid[sidx] <= 1'b1;
            end
            r_s1_valid <= accept;
            if (accept) begin
                r_s1_req <= i_req_type;
                r_rd_vld <= sym_ok && r_cvalid[sidx];
            end
        end
    end

    assign o_push = r_s1_valid &&
                    ((r_s1_req == chenc_pkg::REQ_ENCODE && r_rd_vld) ||
                     r_s1_req == chenc_pkg::REQ_FLUSH);

    assign o_job.is_flush = (r_s1_req == chenc_pkg::REQ_FLUSH);
    assign o_job.len      = r_rd_word[LW+CW-1:CW];
    assign o_job.code     = r_rd_word[CW-1:0];

endmodule

`default_nettype wire

// File: hdl/chenc_queue.sv
// ----------------------------------------------------------------------------
// chenc_queue
// short job queue between the table front end and the bit packer
// ----------------------------------------------------------------------------
`default_nettype none

module chenc_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire chenc_pkg::t_job    i_job,
    input  wire logic               i_pop,
    output chenc_pkg::t_job         o_head,
    output chenc_pkg::t_qstat       o_qstat
);

    localparam int PW = chenc_pkg::QPTR_W;
    localparam int D  = chenc_pkg::QDEPTH;

    chenc_pkg::t_job r_q [0:D-1];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [PW:0]     r_cnt;

    logic do_push;
    logic do_pop;

    assign o_qstat.empty       = (r_cnt == '0);
    assign o_qstat.full        = (r_cnt == (PW+1)'(D));
    assign o_qstat.almost_full = (r_cnt >= (PW+1)'(D - 1));
    assign o_head              = r_q[r_rd];

    assign do_push = i_push && !o_qstat.full;
    assign do_pop  = i_pop && !o_qstat.empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= PW'(r_wr + 1'b1);
            end
            if (do_pop) begin
                r_rd <= PW'(r_rd + 1'b1);
            end
            r_cnt <= (PW+1)'(r_cnt + (PW+1)'(do_push) - (PW+1)'(do_pop));
        end
    end

endmodule

`default_nettype wire

// File: hdl/chenc_back.sv
// ----------------------------------------------------------------------------
// chenc_back
// msb-first bit packer: takes code jobs from the queue and emits full bytes,
// and on flush the zero-padded partial byte, through an output register
// ----------------------------------------------------------------------------
`default_nettype none

module chenc_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire chenc_pkg::t_job                i_head,
    input  wire chenc_pkg::t_qstat              i_qstat,
    output logic                                o_pop,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic [chenc_pkg::BYTE_W-1:0]        o_packed_byte,
    output logic                                o_last_of_run
);

    localparam int LW = chenc_pkg::LEN_W;
    localparam int HW = chenc_pkg::SH_W;
    localparam int BW = chenc_pkg::BYTE_W;
    localparam logic [LW-1:0] MAXL_L = LW'(chenc_pkg::MAX_CODE_LEN);

    logic          r_busy;
    logic          r_flush;
    logic [HW-1:0] r_sh;
    logic [LW-1:0] r_left;
    logic [BW-1:0] r_buf;
    logic [2:0]    r_pend;
    logic          r_out_valid;
    logic [BW-1:0] r_out_byte;
    logic          r_out_last;

    logic          can_go;
    logic [LW-1:0] avail;
    logic [LW-1:0] take;
    logic [LW-1:0] fill;
    logic [LW-1:0] rest;
    logic [BW-1:0] nbuf;
    logic [HW-1:0] load_sh;

    assign can_go = !r_out_valid || !i_stall;
    assign o_pop  = !r_busy && !i_qstat.empty;

    assign avail   = LW'(8) - LW'(r_pend);
    assign take    = (r_left < avail) ? r_left : avail;
    assign fill    = LW'(r_pend) + take;
    assign rest    = LW'(r_left - take);
    assign nbuf    = r_buf | (r_sh[HW-1 -: BW] >> r_pend);
    assign load_sh = {i_head.code, BW'(0)} << (MAXL_L - i_head.len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_flush     <= 1'b0;
            r_sh        <= '0;
            r_left      <= '0;
            r_buf       <= '0;
            r_pend      <= '0;
            r_out_valid <= 1'b0;
            r_out_byte  <= '0;
            r_out_last  <= 1'b0;
        end else begin
            if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                r_busy  <= 1'b1;
                r_flush <= i_head.is_flush;
                r_sh    <= load_sh;
                r_left  <= i_head.len;
            end else if (r_busy && can_go) begin
                if (r_flush) begin
                    r_busy <= 1'b0;
                    if (r_pend != '0) begin
                        r_out_valid <= 1'b1;
                        r_out_byte  <= r_buf;
                        r_out_last  <= 1'b1;
                        r_buf       <= '0;
                        r_pend      <= '0;
                    end
                end else begin
                    r_sh   <= r_sh << take;
                    r_left <= rest;
                    if (rest == '0) begin
                        r_busy <= 1'b0;
                    end
                    if (fill == LW'(8)) begin
                        r_out_valid <= 1'b1;
                        r_out_byte  <= nbuf;
                        r_out_last  <= (rest < LW'(8));
                        r_buf       <= '0;
                        r_pend      <= '0;
                    end else begin
                        r_buf  <= nbuf;
                        r_pend <= 3'(fill);
                    end
                end
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_packed_byte = r_out_byte;
    assign o_last_of_run = r_out_last;

endmodule

`default_nettype wire

// File: hdl/canonical_huffman_encoder_top.sv
// ----------------------------------------------------------------------------
// canonical_huffman_encoder_top
// canonical huffman code builder and msb-first byte packer
// ----------------------------------------------------------------------------
// request beats come in on i_valid/o_stall: set length count, finalize,
// assign symbol, encode byte, flush. packed bytes leave on o_valid/i_stall,
// o_last_of_run marks the final byte produced by one request.
// longest_code_length sits at apb address 0; the user must write it only while
// idle, the block itself does not enforce this. encode, assign and set-count
// beats are taken one per cycle while the job queue has room and no finalize
// walk runs; finalize holds o_stall while it walks the first-code table one
// length per cycle, from longest_code_length (clamped to 1..16) less one to 1.
// the packer loads each job, then works through it in byte-steps and takes no
// new job until the last is done; it is the rate limit for a long run of
// encodes. o_valid rises once a job has passed the code memory read register,
// the job queue, the packer's load step and the byte-step that fills a byte.
// a stall on the output holds the byte register; the queue then fills and
// o_stall rises. reset clears tables, code valid bits, queue and bit buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module canonical_huffman_encoder_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic [chenc_pkg::REQ_W-1:0]       i_req_type,
    input  wire logic [chenc_pkg::LEN_W-1:0]       i_code_length,
    input  wire logic [chenc_pkg::CNT_W-1:0]       i_symbol_count,
    input  wire logic [chenc_pkg::BYTE_W-1:0]      i_byte_value,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic [chenc_pkg::BYTE_W-1:0]           o_packed_byte,
    output logic                                   o_last_of_run,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [chenc_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [chenc_pkg::PDATA_W-1:0]     pwdata,
    output logic [chenc_pkg::PDATA_W-1:0]          prdata,
    output logic                                   pready
);

    localparam int LW = chenc_pkg::LEN_W;

    logic [LW-1:0]       r_longest;
    logic                push;
    logic                pop;
    logic                fin_busy;
    chenc_pkg::t_job     job;
    chenc_pkg::t_job     head;
    chenc_pkg::t_qstat   qstat;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_longest <= LW'(1);
        end else if (psel && penable && pwrite &&
                     paddr[2] == chenc_pkg::REG_LONGEST) begin
            r_longest <= pwdata[LW-1:0];
        end
    end

    assign prdata = (paddr[2] == chenc_pkg::REG_LONGEST) ?
                    chenc_pkg::PDATA_W'(r_longest) : '0;

    chenc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_req_type     (i_req_type),
        .i_code_length  (i_code_length),
        .i_symbol_count (i_symbol_count),
        .i_byte_value   (i_byte_value),
        .i_longest      (r_longest),
        .i_qstat        (qstat),
        .o_push         (push),
        .o_job          (job),
        .o_fin_busy     (fin_busy)
    );

    chenc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_head  (head),
        .o_qstat (qstat)
    );

    chenc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_qstat       (qstat),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_packed_byte (o_packed_byte),
        .o_last_of_run (o_last_of_run)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (!qstat.full || pop))
        else $error("job queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !qstat.empty)
        else $error("job queue underflow");

    a_fin_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_busy |=> !push)
        else $error("job pushed during finalize walk");

endmodule

`default_nettype wire

// File: sim/huffman_pack_checker.sv
// ----------------------------------------------------------------------------
// huffman_pack_checker
// watches the request, byte and register ports of the canonical huffman
// encoder, keeps its own code tables and bit packer, and compares every
// packed byte beat with the oldest byte it predicts
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module huffman_pack_checker
    import chenc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_req_valid,
    input  wire logic               i_req_stall,
    input  wire logic [REQ_W-1:0]   i_req_type,
    input  wire logic [LEN_W-1:0]   i_code_length,
    input  wire logic [CNT_W-1:0]   i_symbol_count,
    input  wire logic [BYTE_W-1:0]  i_byte_value,
    input  wire logic               i_byte_valid,
    input  wire logic               i_byte_stall,
    input  wire logic [BYTE_W-1:0]  i_packed_byte,
    input  wire logic               i_last_of_run,
    input  wire logic               i_psel,
    input  wire logic               i_penable,
    input  wire logic               i_pwrite,
    input  wire logic [PADDR_W-1:0] i_paddr,
    input  wire logic [PDATA_W-1:0] i_pwdata,
    input  wire logic               i_pready,
    output int                      o_error_count,
    output int                      o_bytes_owed
);

    typedef struct packed {
        logic [BYTE_W-1:0] packed_byte;
        logic              last_of_run;
    } t_out_byte;

    logic [LEN_W-1:0]        longest_len;
    logic [CNT_W-1:0]        len_count   [0:MAX_CODE_LEN];
    logic [MAX_CODE_LEN-1:0] first_code  [0:MAX_CODE_LEN];
    logic [CNT_W-1:0]        next_offset [0:MAX_CODE_LEN];
    logic [MAX_CODE_LEN-1:0] sym_code    [0:ALPHABET-1];
    logic [LEN_W-1:0]        sym_len     [0:ALPHABET-1];
    logic [BYTE_W-1:0]       acc_byte;
    int                      acc_bits;
    int                      error_count;
    t_out_byte               owed_bytes [$];

    task automatic pack_request(input logic [REQ_W-1:0] req, input logic [LEN_W-1:0] len,
                                input logic [CNT_W-1:0] cnt, input logic [BYTE_W-1:0] sym);
        logic      len_ok;
        int        top_len;
        int        i;
        int        k;
        int        n_out;
        t_out_byte staged [0:3];
        len_ok = (len >= 1) && (int'(len) <= MAX_CODE_LEN);
        n_out = 0;
        case (req)
            REQ_SET_COUNT: begin
                if (len_ok) len_count[len] = cnt;
            end
            REQ_FINALIZE: begin
                top_len = int'(longest_len);
                if (top_len < 1) top_len = 1;
                if (top_len > MAX_CODE_LEN) top_len = MAX_CODE_LEN;
                for (i = 0; i <= MAX_CODE_LEN; i++) begin
                    first_code[i] = '0;
                    next_offset[i] = '0;
                end
                for (i = top_len - 1; i >= 1; i--) begin
                    first_code[i] = MAX_CODE_LEN'((int'(first_code[i+1])
                                                   + int'(len_count[i+1])) >> 1);
                end
            end
            REQ_ASSIGN: begin
                if (len_ok && int'(sym) < ALPHABET && next_offset[len] < len_count[len]) begin
                    sym_code[sym] = MAX_CODE_LEN'(int'(first_code[len]) + int'(next_offset[len]));
                    sym_len[sym] = len;
                    next_offset[len] = next_offset[len] + 1'b1;
                end
            end
            REQ_ENCODE: begin
                if (int'(sym) < ALPHABET && sym_len[sym] != 0) begin
                    for (k = int'(sym_len[sym]) - 1; k >= 0; k--) begin
                        acc_byte[7 - acc_bits] = sym_code[sym][k];
                        acc_bits++;
                        if (acc_bits == 8) begin
                            staged[n_out] = '{packed_byte: acc_byte, last_of_run: 1'b0};
                            n_out++;
                            acc_byte = '0;
                            acc_bits = 0;
                        end
                    end
                    if (n_out > 0) staged[n_out-1].last_of_run = 1'b1;
                    for (i = 0; i < n_out; i++) owed_bytes.push_back(staged[i]);
                end
            end
            REQ_FLUSH: begin
                if (acc_bits != 0) begin
                    owed_bytes.push_back('{packed_byte: acc_byte, last_of_run: 1'b1});
                    acc_byte = '0;
                    acc_bits = 0;
                end
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_out_byte want;
        if (!i_rst_n) begin
            longest_len = LEN_W'(1);
            for (int i = 0; i <= MAX_CODE_LEN; i++) begin
                len_count[i] = '0;
                first_code[i] = '0;
                next_offset[i] = '0;
            end
            for (int s = 0; s < ALPHABET; s++) begin
                sym_code[s] = '0;
                sym_len[s] = '0;
            end
            acc_byte = '0;
            acc_bits = 0;
            owed_bytes.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready
                    && i_paddr == (PADDR_W'(REG_LONGEST) << 2)) begin
                longest_len = i_pwdata[LEN_W-1:0];
            end
            if (i_req_valid && !i_req_stall) begin
                pack_request(i_req_type, i_code_length, i_symbol_count, i_byte_value);
            end
            if (i_byte_valid && !i_byte_stall) begin
                if (owed_bytes.size() == 0) begin
                    $error("packed_byte: expected none, actual 0x%02h", i_packed_byte);
                    error_count++;
                end else begin
                    want = owed_bytes.pop_front();
                    if (i_packed_byte !== want.packed_byte) begin
                        $error("packed_byte: expected 0x%02h, actual 0x%02h",
                               want.packed_byte, i_packed_byte);
                        error_count++;
                    end
                    if (i_last_of_run !== want.last_of_run) begin
                        $error("last_of_run: expected %0b, actual %0b",
                               want.last_of_run, i_last_of_run);
                        error_count++;
                    end
                end
            end
        end
        o_error_count <= error_count;
        o_bytes_owed <= owed_bytes.size();
    end

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the canonical huffman encoder
// ----------------------------------------------------------------------------
// a directed opening covers ignored request codes, bad lengths, assigns past
// a length's count, bytes without a code and empty flushes. then code phases
// run at several longest-length settings: set counts, finalize, assign
// symbols, encode bytes and flush, with noise beats mixed in. both sides
// idle at random, and once the byte side holds off long enough to fill the
// block. a watchdog ends the run when nothing moves for too long.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import chenc_pkg::*;

    localparam int RANDOM_REQUESTS = 300;
    localparam int QUIET_CYCLES    = 32;
    localparam int HOLD_CYCLES     = 300;
    localparam int WATCHDOG_LIMIT  = 5000;

    localparam logic [REQ_W-1:0] REQ_SPARE_FIRST = REQ_FLUSH + 1'b1;
    localparam logic [REQ_W-1:0] REQ_SPARE_LAST  = '1;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [REQ_W-1:0]   i_req_type;
    logic [LEN_W-1:0]   i_code_length;
    logic [CNT_W-1:0]   i_symbol_count;
    logic [BYTE_W-1:0]  i_byte_value;
    logic               o_valid;
    logic               i_stall;
    logic [BYTE_W-1:0]  o_packed_byte;
    logic               o_last_of_run;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int   mismatch_count;
    int   bytes_owed;
    int   requests_sent;
    logic quiet_sender;
    logic hold_output;
    logic hold_done;

    always #4 i_clk = ~i_clk;

    canonical_huffman_encoder_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_req_type     (i_req_type),
        .i_code_length  (i_code_length),
        .i_symbol_count (i_symbol_count),
        .i_byte_value   (i_byte_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_packed_byte  (o_packed_byte),
        .o_last_of_run  (o_last_of_run),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    huffman_pack_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (i_valid),
        .i_req_stall    (o_stall),
        .i_req_type     (i_req_type),
        .i_code_length  (i_code_length),
        .i_symbol_count (i_symbol_count),
        .i_byte_value   (i_byte_value),
        .i_byte_valid   (o_valid),
        .i_byte_stall   (i_stall),
        .i_packed_byte  (o_packed_byte),
        .i_last_of_run  (o_last_of_run),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_pready       (pready),
        .o_error_count  (mismatch_count),
        .o_bytes_owed   (bytes_owed)
    );

    task automatic send_request(input logic [REQ_W-1:0] req, input logic [LEN_W-1:0] len,
                                input logic [CNT_W-1:0] cnt, input logic [BYTE_W-1:0] val);
        int r;
        int gap;
        r = $urandom_range(0, 99);
        if (quiet_sender || r < 60) gap = 0;
        else if (r < 90) gap = $urandom_range(1, 3);
        else if (r < 98) gap = $urandom_range(4, 10);
        else gap = $urandom_range(20, 40);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_req_type <= req;
        i_code_length <= len;
        i_symbol_count <= cnt;
        i_byte_value <= val;
        do @(posedge i_clk); while (o_stall);
        requests_sent++;
    endtask

    task automatic send_noise();
        send_request(REQ_W'($urandom_range(0, 7)), LEN_W'($urandom_range(0, 31)),
                     CNT_W'($urandom_range(0, 511)), BYTE_W'($urandom_range(0, 255)));
    endtask

    // drop valid, drain all predicted bytes, then let any finalize walk finish
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        wait (bytes_owed == 0);
        repeat (QUIET_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_longest(input logic [LEN_W-1:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(REG_LONGEST) << 2;
        pwdata <= PDATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    initial begin : byte_sink
        int span;
        int r;
        forever begin
            @(negedge i_clk);
            if (hold_output && !hold_done) begin
                hold_done = 1'b1;
                i_stall <= 1'b1;
                span = HOLD_CYCLES;
            end else if (i_stall) begin
                i_stall <= 1'b0;
                span = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                    : $urandom_range(1, 12);
            end else begin
                i_stall <= 1'b1;
                r = $urandom_range(0, 19);
                if (r < 14) span = $urandom_range(1, 2);
                else if (r < 19) span = $urandom_range(3, 8);
                else span = $urandom_range(20, 40);
            end
            repeat (span - 1) @(negedge i_clk);
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || psel) idle = 0;
            else idle++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        logic [LEN_W-1:0]  longest;
        logic [CNT_W-1:0]  count;
        logic [BYTE_W-1:0] sym;
        logic [BYTE_W-1:0] coded_syms [$];
        int                len_budget [1:MAX_CODE_LEN];
        int                top_len;
        int                phase_no;
        int                len;
        int                j;
        int                n;
        int                r;

        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_req_type = REQ_FLUSH;
        i_code_length = '0;
        i_symbol_count = '0;
        i_byte_value = '0;
        i_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        quiet_sender = 1'b0;
        hold_output = 1'b0;
        hold_done = 1'b0;
        requests_sent = 0;

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed opening, longest length 3
        write_longest(LEN_W'(3));
        send_request(REQ_FLUSH, '0, '0, '0);
        send_request(REQ_ENCODE, '0, '0, 8'h00);
        send_request(REQ_SPARE_FIRST, 5'd1, 9'd1, 8'h01);
        send_request(REQ_SPARE_LAST, 5'd31, 9'd511, 8'hFF);
        send_request(REQ_SET_COUNT, 5'd0, 9'd511, 8'h00);
        send_request(REQ_SET_COUNT, 5'd17, 9'd5, 8'h00);
        send_request(REQ_SET_COUNT, 5'd16, 9'd256, 8'h00);
        send_request(REQ_SET_COUNT, 5'd1, 9'd1, 8'h00);
        send_request(REQ_SET_COUNT, 5'd2, 9'd1, 8'h00);
        send_request(REQ_SET_COUNT, 5'd3, 9'd2, 8'h00);
        send_request(REQ_FINALIZE, 5'd0, 9'd0, 8'h00);
        send_request(REQ_ASSIGN, 5'd1, 9'd0, 8'hFF);
        send_request(REQ_ASSIGN, 5'd1, 9'd0, 8'h01);
        send_request(REQ_ASSIGN, 5'd0, 9'd0, 8'h05);
        send_request(REQ_ASSIGN, 5'd31, 9'd0, 8'h06);
        send_request(REQ_ASSIGN, 5'd2, 9'd0, 8'h00);
        send_request(REQ_ASSIGN, 5'd3, 9'd0, 8'h80);
        send_request(REQ_ASSIGN, 5'd3, 9'd0, 8'h7F);
        send_request(REQ_ENCODE, 5'd0, 9'd0, 8'hFF);
        send_request(REQ_ENCODE, 5'd0, 9'd0, 8'h00);
        send_request(REQ_ENCODE, 5'd0, 9'd0, 8'h80);
        send_request(REQ_ENCODE, 5'd0, 9'd0, 8'h7F);
        send_request(REQ_ENCODE, 5'd0, 9'd0, 8'h01);
        send_request(REQ_ENCODE, 5'd0, 9'd0, 8'h80);
        send_request(REQ_FLUSH, 5'd0, 9'd0, 8'h00);

        requests_sent = 0;
        phase_no = 0;
        while (requests_sent < RANDOM_REQUESTS) begin
            case (phase_no)
                0: longest = LEN_W'(MAX_CODE_LEN);
                1: longest = LEN_W'(1);
                2: longest = LEN_W'(0);
                3: longest = '1;
                default: longest = ($urandom_range(0, 3) == 0)
                                   ? LEN_W'($urandom_range(0, 31))
                                   : LEN_W'($urandom_range(1, MAX_CODE_LEN));
            endcase
            settle();
            write_longest(longest);
            quiet_sender = ($urandom_range(0, 3) == 0);
            top_len = int'(longest);
            if (top_len < 1) top_len = 1;
            if (top_len > MAX_CODE_LEN) top_len = MAX_CODE_LEN;
            coded_syms.delete();

            for (len = 1; len <= top_len; len++) begin
                if ($urandom_range(0, 9) == 0) send_noise();
                if ($urandom_range(0, 5) == 0) begin
                    // keep whatever count this length already holds
                    len_budget[len] = $urandom_range(0, 1);
                end else begin
                    r = $urandom_range(0, 19);
                    if (r < 16) count = CNT_W'($urandom_range(0, 3));
                    else if (r < 19) count = CNT_W'($urandom_range(4, 16));
                    else count = CNT_W'($urandom_range(0, 511));
                    len_budget[len] = int'(count);
                    send_request(REQ_SET_COUNT, LEN_W'(len), count,
                                 BYTE_W'($urandom_range(0, 255)));
                end
            end
            send_request(REQ_FINALIZE, LEN_W'($urandom_range(0, 31)),
                         CNT_W'($urandom_range(0, 511)), BYTE_W'($urandom_range(0, 255)));

            for (len = 1; len <= top_len; len++) begin
                n = (len_budget[len] < 3) ? len_budget[len] : 3;
                if ($urandom_range(0, 4) == 0) n++;
                for (j = 0; j < n; j++) begin
                    if ($urandom_range(0, 9) == 0) send_noise();
                    sym = BYTE_W'($urandom_range(0, 255));
                    send_request(REQ_ASSIGN, LEN_W'(len), CNT_W'($urandom_range(0, 511)), sym);
                    coded_syms.push_back(sym);
                end
            end

            n = (phase_no == 0) ? 60 : $urandom_range(20, 40);
            if (phase_no == 0) hold_output = 1'b1;
            for (j = 0; j < n; j++) begin
                if ($urandom_range(0, 9) == 0) send_noise();
                if (coded_syms.size() != 0 && $urandom_range(0, 6) != 0)
                    sym = coded_syms[$urandom_range(0, coded_syms.size() - 1)];
                else
                    sym = BYTE_W'($urandom_range(0, 255));
                send_request(REQ_ENCODE, LEN_W'($urandom_range(0, 31)),
                             CNT_W'($urandom_range(0, 511)), sym);
            end
            if ($urandom_range(0, 3) != 0) begin
                send_request(REQ_FLUSH, LEN_W'($urandom_range(0, 31)),
                             CNT_W'($urandom_range(0, 511)), BYTE_W'($urandom_range(0, 255)));
            end
            phase_no++;
        end

        settle();
        if (mismatch_count == 0 && bytes_owed == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
